FILE: rtl/core/rgbblend_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbblend_pkg
// Shared types, register indexes and helper functions of the RGB332 blender.
// ----------------------------------------------------------------------------
package rgbblend_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [1:0] {
        FMT_FILL   = 2'd0,
        FMT_RGB332 = 2'd1,
        FMT_ARGB   = 2'd2,
        FMT_NONE   = 2'd3
    } src_fmt_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SOURCE_FORMAT = 3'd0,
        REG_FILL_COLOR    = 3'd1,
        REG_OPACITY       = 3'd2,
        REG_MASK_ENABLE   = 3'd3,
        REG_NORMAL_MODE   = 3'd4,
        REG_FULL_LEVEL    = 3'd5
    } cfg_reg_t;

    // where the effective alpha comes from once the products are known
    typedef enum logic [1:0] {
        MIX_DIRECT = 2'd0,
        MIX_PROD8  = 2'd1,
        MIX_PROD16 = 2'd2
    } mix_src_t;

    typedef struct packed {
        src_fmt_t    source_format;
        logic [23:0] fill_color;
        logic [7:0]  opacity;
        logic        mask_enable;
        logic        normal_mode;
        logic [7:0]  full_opacity_level;
    } cfg_t;

    typedef struct packed {
        logic [7:0] dest;
        logic [7:0] src;
        logic [7:0] mix;
    } pix_t;

    localparam cfg_t CFG_RESET = '{
        source_format:      FMT_FILL,
        fill_color:         24'h000000,
        opacity:            8'd255,
        mask_enable:        1'b0,
        normal_mode:        1'b1,
        full_opacity_level: 8'd253
    };

    function automatic logic [7:0] pack332(input logic [23:0] rgb);
        return {rgb[23:21], rgb[15:13], rgb[7:6]};
    endfunction

    // bits taken from the source for each blend step
    function automatic logic [7:0] keep_src_mask(input logic [2:0] k);
        logic [7:0] m;
        unique case (k)
            3'd0: m = 8'b11111111;
            3'd1: m = 8'b11011011;
            3'd2: m = 8'b10110110;
            3'd3: m = 8'b10010010;
            3'd4: m = 8'b01101101;
            3'd5: m = 8'b01001001;
            3'd6: m = 8'b00100100;
            3'd7: m = 8'b00000000;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/core/rgb332_mask_select_blend_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb332_mask_select_blend_unit
// Per-pixel RGB332 blend of a fill, RGB332 or ARGB8888 source onto the
// destination, with global opacity and an optional coverage mask.
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_ready carries one pixel item: dest_pixel,
//   src_color, src_alpha and mask_value. output channel out_valid/out_ready
//   returns one result_pixel per item, in order.
//   configuration channel cfg_valid/cfg_ready writes register cfg_index with
//   cfg_data; cfg_ready is always high. write it only while no item is in
//   flight. unused indexes are ignored.
//   an accepted item passes three registered stages (decode/first product,
//   third factor/alpha select, mask select) before it shows on the outputs.
//   throughput: one item per cycle while out_ready is held high; the
//   multipliers on the path are one 8x8 in stage 1 and one 16x8 in stage 2.
//   reset clears all stage valid bits and loads the register defaults
//   (fill source, opacity 255, mask off, normal mode, full level 253).
//   when the receiver stalls, the three stages fill and hold their items;
//   in_ready drops only once every stage is occupied.
// ----------------------------------------------------------------------------
module rgb332_mask_select_blend_unit
    import rgbblend_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             dest_pixel,
    input  logic [23:0]            src_color,
    input  logic [7:0]             src_alpha,
    input  logic [7:0]             mask_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             result_pixel
);

    cfg_t cfg;
    logic alpha_valid;
    logic alpha_ready;
    pix_t alpha_pix;

    rgbblend_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rgbblend_alpha u_alpha (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .dest_pixel (dest_pixel),
        .src_color  (src_color),
        .src_alpha  (src_alpha),
        .mask_value (mask_value),
        .out_valid  (alpha_valid),
        .out_ready  (alpha_ready),
        .out_pix    (alpha_pix)
    );

    rgbblend_mix u_mix (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (alpha_valid),
        .in_ready     (alpha_ready),
        .in_pix       (alpha_pix),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_pixel (result_pixel)
    );

endmodule

FILE: rtl/core/rgbblend_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbblend_cfg
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module rgbblend_cfg
    import rgbblend_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SOURCE_FORMAT: cfg_next.source_format      = src_fmt_t'(cfg_data[1:0]);
                REG_FILL_COLOR:    cfg_next.fill_color         = cfg_data[23:0];
                REG_OPACITY:       cfg_next.opacity            = cfg_data[7:0];
                REG_MASK_ENABLE:   cfg_next.mask_enable        = cfg_data[0];
                REG_NORMAL_MODE:   cfg_next.normal_mode        = cfg_data[0];
                REG_FULL_LEVEL:    cfg_next.full_opacity_level = cfg_data[7:0];
                default:           cfg_next = cfg_reg;   // unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/rgbblend_alpha.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbblend_alpha
// Two pipeline stages: source decode with the first 8x8 product, then the
// optional third factor and the choice of the effective alpha.
// ----------------------------------------------------------------------------
module rgbblend_alpha
    import rgbblend_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  dest_pixel,
    input  logic [23:0] src_color,
    input  logic [7:0]  src_alpha,
    input  logic [7:0]  mask_value,
    output logic        out_valid,
    input  logic        out_ready,
    output pix_t        out_pix
);

    // stage 1 decode
    logic        full_rule;
    logic [7:0]  mul_a;
    logic [7:0]  mul_b;
    logic [7:0]  direct_val;
    logic [7:0]  src_val;
    mix_src_t    sel_val;

    logic        s1_valid_reg;
    logic        s1_ready;
    logic [7:0]  s1_dest_reg;
    logic [7:0]  s1_src_reg;
    logic [7:0]  s1_direct_reg;
    logic [15:0] s1_prod_reg;
    logic [7:0]  s1_mask_reg;
    mix_src_t    s1_sel_reg;

    logic [23:0] prod3;
    logic [7:0]  mix_next;

    logic        s2_valid_reg;
    logic        s2_ready;
    logic [7:0]  s2_dest_reg;
    logic [7:0]  s2_src_reg;
    logic [7:0]  s2_mix_reg;

    always_comb
    begin
        mul_a      = 8'd0;
        mul_b      = 8'd0;
        direct_val = 8'd0;
        sel_val    = MIX_DIRECT;
        src_val    = dest_pixel;
        // solid fill keeps the full-opacity shortcut in every mode
        full_rule  = (cfg.opacity >= cfg.full_opacity_level) &&
                     (cfg.source_format == FMT_FILL || cfg.normal_mode);
        unique case (cfg.source_format)
            FMT_FILL, FMT_RGB332:
            begin
                src_val = (cfg.source_format == FMT_FILL) ? pack332(cfg.fill_color)
                                                          : src_color[7:0];
                if (full_rule)
                begin
                    direct_val = cfg.mask_enable ? mask_value : 8'hFF;
                end
                else if (cfg.mask_enable)
                begin
                    mul_a   = mask_value;
                    mul_b   = cfg.opacity;
                    sel_val = MIX_PROD8;
                end
                else
                begin
                    direct_val = cfg.opacity;
                end
            end
            FMT_ARGB:
            begin
                src_val = pack332(src_color);
                mul_a   = src_alpha;
                if (full_rule)
                begin
                    mul_b      = mask_value;
                    direct_val = src_alpha;
                    sel_val    = cfg.mask_enable ? MIX_PROD8 : MIX_DIRECT;
                end
                else
                begin
                    mul_b   = cfg.opacity;
                    sel_val = cfg.mask_enable ? MIX_PROD16 : MIX_PROD8;
                end
            end
            FMT_NONE:
            begin
                // zero alpha keeps the destination
                direct_val = 8'd0;
            end
        endcase
    end

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_dest_reg   <= dest_pixel;
            s1_src_reg    <= src_val;
            s1_direct_reg <= direct_val;
            s1_prod_reg   <= mul_a * mul_b;
            s1_mask_reg   <= mask_value;
            s1_sel_reg    <= sel_val;
        end
    end

    assign prod3 = s1_prod_reg * s1_mask_reg;

    always_comb
    begin
        unique case (s1_sel_reg)
            MIX_DIRECT: mix_next = s1_direct_reg;
            MIX_PROD8:  mix_next = s1_prod_reg[15:8];
            MIX_PROD16: mix_next = prod3[23:16];
            default:    mix_next = s1_direct_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_dest_reg <= s1_dest_reg;
            s2_src_reg  <= s1_src_reg;
            s2_mix_reg  <= mix_next;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign out_pix.dest = s2_dest_reg;
    assign out_pix.src  = s2_src_reg;
    assign out_pix.mix  = s2_mix_reg;

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !out_ready |=> s2_valid_reg && $stable(s2_mix_reg)
                                       && $stable(s2_dest_reg))
        else $error("stage 2 item changed while stalled");

    a_direct_pass: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_ready && s1_sel_reg == MIX_DIRECT
        |=> s2_mix_reg == $past(s1_direct_reg))
        else $error("direct alpha not carried to stage 2");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(s1_prod_reg)
                                      && $stable(s1_sel_reg))
        else $error("stage 1 item changed while stalled");

endmodule

FILE: rtl/core/rgbblend_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbblend_mix
// Output stage: alpha to blend step, bit-mask select between source and
// destination, result register.
// ----------------------------------------------------------------------------
module rgbblend_mix
    import rgbblend_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  pix_t       in_pix,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] result_pixel
);

    logic [2:0] step;
    logic [7:0] keep;
    logic [7:0] result_next;
    logic       valid_reg;
    logic [7:0] result_reg;

    // 255 - mix on eight bits is the complement
    assign step        = ~in_pix.mix[7:5];
    assign keep        = keep_src_mask(step);
    assign result_next = (in_pix.src & keep) | (in_pix.dest & ~keep);

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = valid_reg;
    assign result_pixel = result_reg;

    a_low_alpha_keeps_dest: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_pix.mix[7:5] == 3'b000
        |=> result_reg == $past(in_pix.dest))
        else $error("low alpha did not keep destination");

    a_high_alpha_takes_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_pix.mix[7:5] == 3'b111
        |=> result_reg == $past(in_pix.src))
        else $error("high alpha did not take source");

    a_bits_from_inputs: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready
        |=> ((result_reg ^ $past(in_pix.src)) & (result_reg ^ $past(in_pix.dest)))
            == 8'd0)
        else $error("result bit from neither source nor destination");

endmodule

FILE: tb/rgb332_blend_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb332_blend_checker
// Watches the register, pixel and result channels of the RGB332 blender,
// keeps its own copy of the registers, works out each blended pixel as an
// item is accepted and compares every accepted result with the oldest one.
// ----------------------------------------------------------------------------
module rgb332_blend_checker
    import rgbblend_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [7:0]             dest_pixel,
    input  logic [23:0]            src_color,
    input  logic [7:0]             src_alpha,
    input  logic [7:0]             mask_value,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [7:0]             result_pixel,
    output int                     errors = 0,
    output int                     pending = 0
);

    localparam int PRINT_LIMIT = 40;

    // source bits kept per blend step, step 0 in the low byte
    localparam logic [63:0] SRC_BIT_TABLE = 64'h00_24_49_6D_92_B6_DB_FF;

    src_fmt_t    r_format;
    logic [23:0] r_fill;
    logic [7:0]  r_opacity;
    logic        r_mask_en;
    logic        r_normal;
    logic [7:0]  r_full_level;

    logic [7:0]  expected_pixels[$];

    function automatic logic [7:0] to_rgb332(input logic [23:0] rgb);
        return {rgb[23:21], rgb[15:13], rgb[7:6]};
    endfunction

    function automatic logic [7:0] predict_pixel(input logic [7:0] dst,
                                                 input logic [23:0] scol,
                                                 input logic [7:0] alpha,
                                                 input logic [7:0] cov);
        logic [7:0]  src;
        logic [7:0]  mix;
        logic [7:0]  keep;
        logic [2:0]  step;
        logic        full;
        int unsigned prod;
        full = (r_opacity >= r_full_level);
        case (r_format)
            FMT_FILL, FMT_RGB332:
            begin
                src = (r_format == FMT_FILL) ? to_rgb332(r_fill) : scol[7:0];
                // solid fill keeps the full-opacity shortcut in every mode
                if (r_format == FMT_RGB332 && !r_normal)
                    full = 1'b0;
                prod = cov * r_opacity;
                if (full)
                    mix = r_mask_en ? cov : 8'hFF;
                else
                    mix = r_mask_en ? 8'(prod >> 8) : r_opacity;
            end
            FMT_ARGB:
            begin
                src = to_rgb332(scol);
                if (!r_normal)
                    full = 1'b0;
                if (full)
                begin
                    prod = alpha * cov;
                    mix = r_mask_en ? 8'(prod >> 8) : alpha;
                end
                else
                begin
                    prod = alpha * r_opacity;
                    if (r_mask_en)
                    begin
                        prod = prod * cov;
                        mix = 8'(prod >> 16);
                    end
                    else
                        mix = 8'(prod >> 8);
                end
            end
            default:
                return dst;
        endcase
        step = 3'((8'd255 - mix) >> 5);
        keep = SRC_BIT_TABLE[step * 8 +: 8];
        return (src & keep) | (dst & ~keep);
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < PRINT_LIMIT)
            $display("[%0t] blend check: %s", $time, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0] want;
        if (!rst_n)
        begin
            r_format     <= FMT_FILL;
            r_fill       <= 24'h000000;
            r_opacity    <= 8'd255;
            r_mask_en    <= 1'b0;
            r_normal     <= 1'b1;
            r_full_level <= 8'd253;
            expected_pixels.delete();
            pending      <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SOURCE_FORMAT: r_format     <= src_fmt_t'(cfg_data[1:0]);
                    REG_FILL_COLOR:    r_fill       <= cfg_data[23:0];
                    REG_OPACITY:       r_opacity    <= cfg_data[7:0];
                    REG_MASK_ENABLE:   r_mask_en    <= cfg_data[0];
                    REG_NORMAL_MODE:   r_normal     <= cfg_data[0];
                    REG_FULL_LEVEL:    r_full_level <= cfg_data[7:0];
                    default:           ;
                endcase
            end
            // results first, so an item accepted at this edge never pairs with one
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch($sformatf("result_pixel %02h with no item waiting",
                                              result_pixel));
                else
                begin
                    want = expected_pixels.pop_front();
                    if (result_pixel !== want)
                        report_mismatch($sformatf("result_pixel exp %02h got %02h",
                                                  want, result_pixel));
                end
            end
            if (in_valid && in_ready)
                expected_pixels.push_back(predict_pixel(dest_pixel, src_color,
                                                        src_alpha, mask_value));
            pending <= expected_pixels.size();
        end
    end

endmodule

FILE: tb/tb_rgb332_mask_select_blend_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb332_mask_select_blend_unit
// Drives pixel items through the RGB332 blender under a sequence of register
// settings: a directed pass over formats, modes and alpha extremes, then
// random settings with random pixels, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_rgb332_mask_select_blend_unit;
    import rgbblend_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_COUNT  = 30;
    localparam int PHASE_ITEMS  = 55;
    localparam int STEADY_PHASE = 12;
    localparam int DRAIN_CYCLES = 8;

    // indexes past the last register, writes there must change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    logic [7:0]             dest_pixel = '0;
    logic [23:0]            src_color  = '0;
    logic [7:0]             src_alpha  = '0;
    logic [7:0]             mask_value = '0;
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic [7:0]             result_pixel;

    logic no_idle      = 1'b0;
    int   mismatches;
    int   pending;
    int   quiet_cycles = 0;

    always #2 clk = ~clk;

    rgb332_mask_select_blend_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .dest_pixel   (dest_pixel),
        .src_color    (src_color),
        .src_alpha    (src_alpha),
        .mask_value   (mask_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_pixel (result_pixel)
    );

    rgb332_blend_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .dest_pixel   (dest_pixel),
        .src_color    (src_color),
        .src_alpha    (src_alpha),
        .mask_value   (mask_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_pixel (result_pixel),
        .errors       (mismatches),
        .pending      (pending)
    );

    always @(posedge clk)
        out_ready <= no_idle || ($urandom_range(99) >= 30);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // raises the write and leaves it up, set_config lowers it after the last one
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // unused upper data bits carry random junk
    task automatic set_config(input src_fmt_t fmt, input logic [23:0] fill,
                              input logic [7:0] opac, input logic mask_en,
                              input logic normal, input logic [7:0] level,
                              input logic stray);
        write_reg(REG_SOURCE_FORMAT, {22'($urandom()), fmt});
        write_reg(REG_FILL_COLOR, fill);
        write_reg(REG_OPACITY, {16'($urandom()), opac});
        write_reg(REG_MASK_ENABLE, {23'($urandom()), mask_en});
        write_reg(REG_NORMAL_MODE, {23'($urandom()), normal});
        write_reg(REG_FULL_LEVEL, {16'($urandom()), level});
        if (stray)
        begin
            write_reg(REG_SPARE_A, 24'($urandom()));
            write_reg(REG_SPARE_B, 24'($urandom()));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic push_pixel(input logic [7:0] d, input logic [23:0] s,
                              input logic [7:0] a, input logic [7:0] m);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 30)
            gap = $urandom_range(1, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        dest_pixel <= d;
        src_color  <= s;
        src_alpha  <= a;
        mask_value <= m;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // the extra edge lets the checker count the item accepted last
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'($urandom_range(1, 40));
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic src_fmt_t pick_format();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 2)
            return FMT_FILL;
        if (r < 5)
            return FMT_RGB332;
        if (r < 9)
            return FMT_ARGB;
        return FMT_NONE;
    endfunction

    initial
    begin
        logic [7:0] level;
        logic [7:0] opac;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: black fill at full opacity
        push_pixel(8'hFF, 24'hFFFFFF, 8'hFF, 8'hFF);
        push_pixel(8'h00, 24'h000000, 8'h00, 8'h00);
        drain();

        // fill ignores the mode bit, opacity below the full level
        set_config(FMT_FILL, 24'hFFFFFF, 8'h80, 1'b0, 1'b0, 8'd253, 1'b1);
        push_pixel(8'h00, 24'h000000, 8'h00, 8'h00);
        push_pixel(8'hA5, 24'h123456, 8'hFF, 8'hFF);
        drain();

        // rgb332 image, full opacity, mask extremes
        set_config(FMT_RGB332, 24'h000000, 8'd255, 1'b1, 1'b1, 8'd253, 1'b0);
        push_pixel(8'h00, 24'hFFFFFF, 8'h00, 8'h00);
        push_pixel(8'h00, 24'h0000FF, 8'h00, 8'hFF);
        push_pixel(8'hFF, 24'hFFFF00, 8'hFF, 8'h80);
        drain();

        // rgb332 image in other modes: no full-opacity shortcut
        set_config(FMT_RGB332, 24'hFFFFFF, 8'd254, 1'b0, 1'b0, 8'd0, 1'b0);
        push_pixel(8'h00, 24'h0000FF, 8'h00, 8'hFF);
        push_pixel(8'hFF, 24'hFFFF00, 8'hFF, 8'h00);
        drain();

        // argb at full opacity with mask
        set_config(FMT_ARGB, 24'h000000, 8'd255, 1'b1, 1'b1, 8'd253, 1'b0);
        push_pixel(8'h00, 24'hFFFFFF, 8'hFF, 8'hFF);
        push_pixel(8'hFF, 24'h000000, 8'h00, 8'hFF);
        push_pixel(8'h00, 24'hFFFFFF, 8'hFF, 8'h01);
        drain();

        // argb below full opacity, three-way product then two-way
        set_config(FMT_ARGB, 24'hFFFFFF, 8'd100, 1'b1, 1'b1, 8'd253, 1'b0);
        push_pixel(8'h00, 24'hFFFFFF, 8'hFF, 8'hFF);
        push_pixel(8'h5A, 24'hE0E0C0, 8'hC0, 8'h90);
        drain();
        set_config(FMT_ARGB, 24'hFFFFFF, 8'd100, 1'b0, 1'b1, 8'd253, 1'b0);
        push_pixel(8'h00, 24'hFFFFFF, 8'hFF, 8'h00);
        push_pixel(8'hFF, 24'h1F1F3F, 8'h80, 8'hFF);
        drain();

        // argb in other modes, opacity above a zero full level still scales
        set_config(FMT_ARGB, 24'h000000, 8'd255, 1'b0, 1'b0, 8'd0, 1'b0);
        push_pixel(8'h00, 24'hFFFFFF, 8'hFF, 8'hFF);
        push_pixel(8'hFF, 24'h000000, 8'h20, 8'h00);
        drain();

        // unused source format passes the destination through
        set_config(FMT_NONE, 24'hFFFFFF, 8'd255, 1'b1, 1'b1, 8'd253, 1'b1);
        push_pixel(8'h00, 24'hFFFFFF, 8'hFF, 8'hFF);
        push_pixel(8'hC3, 24'h000000, 8'h00, 8'h00);
        drain();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            no_idle <= (p == STEADY_PHASE);
            case ($urandom_range(3))
                0:       level = 8'd0;
                1:       level = 8'd255;
                default: level = 8'($urandom());
            endcase
            case ($urandom_range(5))
                0:       opac = 8'd0;
                1:       opac = 8'd255;
                2:       opac = level;
                3:       opac = level - 8'd1;
                default: opac = 8'($urandom());
            endcase
            set_config(pick_format(), 24'($urandom()), opac, 1'($urandom()),
                       1'($urandom()), level, $urandom_range(3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                push_pixel(8'($urandom()), 24'($urandom()), pick_byte(), pick_byte());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/rgbblend_pkg.sv
rtl/core/rgbblend_cfg.sv
rtl/core/rgbblend_alpha.sv
rtl/core/rgbblend_mix.sv
rtl/core/rgb332_mask_select_blend_unit.sv
tb/rgb332_blend_checker.sv
tb/tb_rgb332_mask_select_blend_unit.sv
